/* rtl/core/ups_pss_pkg.sv */
package ups_pss_pkg;

	localparam int ModeW = 3;
	localparam int TimeW = 16;
	localparam int DivW  = 10;
	localparam int BstW  = 2;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;

	localparam logic [ModeW-1:0] MODE_INITIAL = 3'd0;
	localparam logic [ModeW-1:0] MODE_ADAPTER = 3'd1;
	localparam logic [ModeW-1:0] MODE_BATTERY = 3'd2;
	localparam logic [ModeW-1:0] MODE_WARNING = 3'd3;
	localparam logic [ModeW-1:0] MODE_UNDERV  = 3'd4;

	localparam logic [BstW-1:0] BST_UNKNOWN = 2'd0;
	localparam logic [BstW-1:0] BST_GOOD    = 2'd3;

	localparam logic [TimeW-1:0] TIME_MAX = 16'hFFFF;

	localparam logic [CfgIdxW-1:0] REG_TICK_DIVIDE   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_AC_GOOD_TICKS = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_WARNING_TICKS = 2'd2;

	localparam logic [DivW-1:0]  TICK_DIVIDE_RST   = 10'd50;
	localparam logic [TimeW-1:0] AC_GOOD_TICKS_RST = 16'd5;
	localparam logic [TimeW-1:0] WARNING_TICKS_RST = 16'd200;

	typedef struct packed {
		logic            power_command;
		logic            mains_on;
		logic [BstW-1:0] battery_status;
		logic            system_tick;
		logic            serial_idle;
	} poll_t;

	typedef struct packed {
		logic             battery_fet;
		logic             adapter_fet;
		logic [ModeW-1:0] mode;
	} result_t;

	typedef struct packed {
		logic [DivW-1:0]  tick_divide;
		logic [TimeW-1:0] ac_good_ticks;
		logic [TimeW-1:0] warning_ticks;
	} cfg_t;

endpackage

/* rtl/core/ups_power_source_switch_fsm.sv */
// channel  | handshake                   | payload
// poll in  | in_valid / in_stall         | power_command mains_on battery_status
//          |                             | system_tick serial_idle
// result   | out_valid / out_stall       | battery_fet adapter_fet mode
// config   | cfg_we                      | cfg_index cfg_data
//
// Two register stages: a poll lands in the input register, the mode logic is
// combinational and its result lands in the output register; one poll per cycle
// unless a stalled result backs up the pipe.
// Mode state updates when the poll moves from input to output register.
// arst_n clears both stages and the mode state and sets the config registers to their reset values.
// A stalled result holds the pipe; in_stall follows out_stall when both stages are full.
module ups_power_source_switch_fsm
	import ups_pss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                power_command,
	input  logic                mains_on,
	input  logic [BstW-1:0]     battery_status,
	input  logic                system_tick,
	input  logic                serial_idle,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                battery_fet,
	output logic                adapter_fet,
	output logic [ModeW-1:0]    mode,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t    cfg;
	poll_t   poll_s1;
	result_t res, res_s2;
	logic    valid_s1, valid_s2, adv, take;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			poll_s1.power_command  <= power_command;
			poll_s1.mains_on       <= mains_on;
			poll_s1.battery_status <= battery_status;
			poll_s1.system_tick    <= system_tick;
			poll_s1.serial_idle    <= serial_idle;
		end
		if (adv)
			res_s2 <= res;
	end

	ups_pss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ups_pss_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.poll   (poll_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid   = valid_s2;
	assign battery_fet = res_s2.battery_fet;
	assign adapter_fet = res_s2.adapter_fet;
	assign mode        = res_s2.mode;

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("poll dropped from input register");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("result not registered");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a full pipe");

endmodule

/* rtl/core/ups_pss_cfg.sv */
module ups_pss_cfg
	import ups_pss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_divide   <= TICK_DIVIDE_RST;
			cfg_q.ac_good_ticks <= AC_GOOD_TICKS_RST;
			cfg_q.warning_ticks <= WARNING_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICK_DIVIDE:   cfg_q.tick_divide   <= cfg_data[DivW-1:0];
				REG_AC_GOOD_TICKS: cfg_q.ac_good_ticks <= cfg_data;
				REG_WARNING_TICKS: cfg_q.warning_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/ups_pss_core.sv */
module ups_pss_core
	import ups_pss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  poll_t   poll,
	input  cfg_t    cfg,
	output result_t res
);

	logic [ModeW-1:0] cur_q, prev_q;
	logic [TimeW-1:0] time_q;
	logic [DivW-1:0]  pre_q;
	logic             bat_q, ada_q;

	logic [ModeW-1:0] cur_n, prev_n;
	logic [TimeW-1:0] time_n;
	logic [DivW-1:0]  pre_n;
	logic             bat_n, ada_n;
	logic [DivW:0]    pre_sum;
	logic             restart, bat_ok, ac_good, warn_done;

	assign restart = (cur_q == MODE_INITIAL) || (cur_q != prev_q);
	assign pre_sum = {1'b0, pre_q} + {{DivW{1'b0}}, poll.system_tick};
	assign bat_ok  = poll.battery_status > 2'd1;

	always_comb begin
		prev_n = prev_q;
		time_n = time_q;
		pre_n  = pre_q;
		if (poll.power_command) begin
			if (restart) begin
				prev_n = cur_q;
				time_n = '0;
				pre_n  = '0;
			end else if (pre_sum >= {1'b0, cfg.tick_divide}) begin
				pre_n = '0;
				if (time_q != TIME_MAX)
					time_n = time_q + 1'b1;
			end else begin
				pre_n = pre_sum[DivW-1:0];
			end
		end
	end

	assign ac_good   = time_n >= cfg.ac_good_ticks;
	assign warn_done = (time_n >= cfg.warning_ticks) && poll.serial_idle;

	logic [ModeW-1:0] cur_r;
	logic             bat_r, ada_r;

	always_comb begin
		cur_r = cur_q;
		bat_r = bat_q;
		ada_r = ada_q;
		if (!poll.power_command) begin
			cur_r = MODE_INITIAL;
			bat_r = 1'b0;
			ada_r = 1'b0;
		end else begin
			unique case (cur_q)
				MODE_INITIAL: begin
					if (poll.mains_on) begin
						bat_r = 1'b0; ada_r = 1'b1; cur_r = MODE_ADAPTER;
					end else if (poll.battery_status != BST_UNKNOWN) begin
						if (bat_ok) begin
							bat_r = 1'b1; ada_r = 1'b0; cur_r = MODE_BATTERY;
						end else begin
							bat_r = 1'b0; ada_r = 1'b0; cur_r = MODE_UNDERV;
						end
					end
				end
				MODE_ADAPTER: begin
					if (poll.mains_on) begin
						if (ac_good)
							bat_r = 1'b0;
					end else if (bat_ok) begin
						bat_r = 1'b1; cur_r = MODE_BATTERY;
					end else begin
						bat_r = 1'b0; ada_r = 1'b0; cur_r = MODE_UNDERV;
					end
				end
				MODE_BATTERY: begin
					if (poll.mains_on) begin
						ada_r = 1'b1; cur_r = MODE_ADAPTER;
					end else if (bat_ok) begin
						if (ac_good)
							ada_r = 1'b0;
					end else begin
						cur_r = MODE_WARNING;
					end
				end
				MODE_WARNING: begin
					if (warn_done)
						cur_r = MODE_UNDERV;
				end
				default: begin
					if (poll.mains_on) begin
						bat_r = 1'b0; ada_r = 1'b1; cur_r = MODE_ADAPTER;
					end else if (poll.battery_status == BST_GOOD) begin
						bat_r = 1'b1; ada_r = 1'b0; cur_r = MODE_BATTERY;
					end else begin
						bat_r = 1'b0; ada_r = 1'b0; cur_r = MODE_UNDERV;
					end
				end
			endcase
		end
	end

	assign cur_n = cur_r;
	assign bat_n = bat_r;
	assign ada_n = ada_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= MODE_INITIAL;
			prev_q <= MODE_INITIAL;
			time_q <= '0;
			pre_q  <= '0;
			bat_q  <= 1'b0;
			ada_q  <= 1'b0;
		end else if (en) begin
			cur_q  <= cur_n;
			prev_q <= prev_n;
			time_q <= time_n;
			pre_q  <= pre_n;
			bat_q  <= bat_n;
			ada_q  <= ada_n;
		end
	end

	assign res.battery_fet = bat_n;
	assign res.adapter_fet = ada_n;
	assign res.mode        = cur_n;

	a_cmd_off: assert property (@(posedge clk) disable iff (!arst_n)
		en && !poll.power_command |=> cur_q == MODE_INITIAL && !bat_q && !ada_q)
		else $error("power off did not force initial mode");

	a_initial_off: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q == MODE_INITIAL |-> !bat_q && !ada_q)
		else $error("FET driven in initial mode");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= MODE_UNDERV)
		else $error("mode out of range");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(time_q) && $stable(pre_q) && $stable(cur_q))
		else $error("state moved without a poll");

endmodule

/* test/tb_ups_power_source_switch_fsm.sv */
module tb_ups_power_source_switch_fsm;
	import ups_pss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
	localparam logic [BstW-1:0] BST_UNDERV = 2'd1;
	localparam logic [BstW-1:0] BST_LOW = 2'd2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic power_command = 1'b0;
	logic mains_on = 1'b0;
	logic [BstW-1:0] battery_status = '0;
	logic system_tick = 1'b0;
	logic serial_idle = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic battery_fet;
	logic adapter_fet;
	logic [ModeW-1:0] mode;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	ups_power_source_switch_fsm dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.power_command(power_command),
		.mains_on(mains_on),
		.battery_status(battery_status),
		.system_tick(system_tick),
		.serial_idle(serial_idle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.battery_fet(battery_fet),
		.adapter_fet(adapter_fet),
		.mode(mode),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6ns clk = 1'b1;
		#6ns clk = 1'b0;
	end

	// predicted switch state and its copy of the registers
	logic [DivW-1:0] div_r = TICK_DIVIDE_RST;
	logic [TimeW-1:0] ac_good_r = AC_GOOD_TICKS_RST;
	logic [TimeW-1:0] warn_r = WARNING_TICKS_RST;
	logic [ModeW-1:0] sw_mode = MODE_INITIAL;
	logic [ModeW-1:0] sw_last_mode = MODE_INITIAL;
	logic [TimeW-1:0] sw_ticks = '0;
	logic [DivW-1:0] sw_prescale = '0;
	logic sw_bat_on = 1'b0;
	logic sw_ada_on = 1'b0;

	poll_t poll_q[$];
	result_t want_drive_q[$];
	int gap_pct = 0;
	int stall_pct = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;

	// random walk of the supply conditions
	logic w_mains = 1'b0;
	logic [BstW-1:0] w_bst = BST_GOOD;
	logic w_idle = 1'b1;

	function automatic int pick_len(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 8);
		return $urandom_range(3, 1);
	endfunction

	function automatic result_t next_drive(poll_t p);
		result_t r;
		logic bat_ok;
		int sum;
		bat_ok = (p.battery_status == BST_LOW) || (p.battery_status == BST_GOOD);
		if (p.power_command) begin
			if (sw_mode == MODE_INITIAL || sw_mode != sw_last_mode) begin
				sw_last_mode = sw_mode;
				sw_ticks = '0;
				sw_prescale = '0;
			end else begin
				sum = int'(sw_prescale) + int'(p.system_tick);
				if (sum >= int'(div_r)) begin
					sw_prescale = '0;
					if (sw_ticks != TIME_MAX)
						sw_ticks = sw_ticks + 1'b1;
				end else begin
					sw_prescale = sum[DivW-1:0];
				end
			end
			case (sw_mode)
				MODE_INITIAL: begin
					if (p.mains_on) begin
						sw_bat_on = 1'b0;
						sw_ada_on = 1'b1;
						sw_mode = MODE_ADAPTER;
					end else if (p.battery_status != BST_UNKNOWN) begin
						sw_bat_on = bat_ok;
						sw_ada_on = 1'b0;
						sw_mode = bat_ok ? MODE_BATTERY : MODE_UNDERV;
					end
				end
				MODE_ADAPTER: begin
					if (p.mains_on) begin
						if (sw_ticks >= ac_good_r)
							sw_bat_on = 1'b0;
					end else if (bat_ok) begin
						sw_bat_on = 1'b1;
						sw_mode = MODE_BATTERY;
					end else begin
						sw_bat_on = 1'b0;
						sw_ada_on = 1'b0;
						sw_mode = MODE_UNDERV;
					end
				end
				MODE_BATTERY: begin
					if (p.mains_on) begin
						sw_ada_on = 1'b1;
						sw_mode = MODE_ADAPTER;
					end else if (bat_ok) begin
						if (sw_ticks >= ac_good_r)
							sw_ada_on = 1'b0;
					end else begin
						sw_mode = MODE_WARNING;
					end
				end
				MODE_WARNING: begin
					if (sw_ticks >= warn_r && p.serial_idle)
						sw_mode = MODE_UNDERV;
				end
				default: begin
					if (p.mains_on) begin
						sw_bat_on = 1'b0;
						sw_ada_on = 1'b1;
						sw_mode = MODE_ADAPTER;
					end else if (p.battery_status == BST_GOOD) begin
						sw_bat_on = 1'b1;
						sw_ada_on = 1'b0;
						sw_mode = MODE_BATTERY;
					end else begin
						sw_bat_on = 1'b0;
						sw_ada_on = 1'b0;
						sw_mode = MODE_UNDERV;
					end
				end
			endcase
		end else begin
			sw_bat_on = 1'b0;
			sw_ada_on = 1'b0;
			sw_mode = MODE_INITIAL;
		end
		r.battery_fet = sw_bat_on;
		r.adapter_fet = sw_ada_on;
		r.mode = sw_mode;
		return r;
	endfunction

	// driver
	poll_t held;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				want_drive_q.push_back(next_drive(held));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (poll_q.size() > 0) begin
					held = poll_q.pop_front();
					power_command <= held.power_command;
					mains_on <= held.mains_on;
					battery_status <= held.battery_status;
					system_tick <= held.system_tick;
					serial_idle <= held.serial_idle;
					in_valid <= 1'b1;
					gap_left = pick_len(gap_pct);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	result_t want;
	int stall_left = 0;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (want_drive_q.size() == 0) begin
				$error("result transfer with no prediction pending");
				mismatch_cnt++;
			end else begin
				want = want_drive_q.pop_front();
				if (battery_fet !== want.battery_fet) begin
					$error("battery_fet: expected %0d, actual %0d", want.battery_fet, battery_fet);
					mismatch_cnt++;
				end
				if (adapter_fet !== want.adapter_fet) begin
					$error("adapter_fet: expected %0d, actual %0d", want.adapter_fet, adapter_fet);
					mismatch_cnt++;
				end
				if (mode !== want.mode) begin
					$error("mode: expected %0d, actual %0d", want.mode, mode);
					mismatch_cnt++;
				end
			end
		end
		stall_left = (stall_left > 0) ? stall_left - 1 : pick_len(stall_pct);
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TICK_DIVIDE: div_r = data[DivW-1:0];
			REG_AC_GOOD_TICKS: ac_good_r = data;
			REG_WARNING_TICKS: warn_r = data;
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [CfgDataW-1:0] div, logic [CfgDataW-1:0] ac,
			logic [CfgDataW-1:0] warn);
		write_reg(REG_TICK_DIVIDE, div);
		write_reg(REG_AC_GOOD_TICKS, ac);
		write_reg(REG_WARNING_TICKS, warn);
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (poll_q.size() != 0 || in_valid || want_drive_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic push(logic cmd, logic mains, logic [BstW-1:0] bst, logic tick, logic idle);
		poll_t p;
		p.power_command = cmd;
		p.mains_on = mains;
		p.battery_status = bst;
		p.system_tick = tick;
		p.serial_idle = idle;
		poll_q.push_back(p);
	endtask

	task automatic fill_random(int n, int tick_pct);
		logic [$bits(poll_t)-1:0] raw;
		poll_t p;
		repeat (n) begin
			if ($urandom_range(99) < 5) begin
				raw = $bits(poll_t)'($urandom);
				p = raw;
			end else begin
				if ($urandom_range(14) == 0)
					w_mains = ~w_mains;
				if ($urandom_range(9) == 0)
					w_bst = BstW'($urandom_range(3));
				if ($urandom_range(7) == 0)
					w_idle = ~w_idle;
				p.power_command = ($urandom_range(59) != 0);
				p.mains_on = w_mains;
				p.battery_status = w_bst;
				p.system_tick = ($urandom_range(99) < tick_pct);
				p.serial_idle = w_idle;
			end
			poll_q.push_back(p);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset values of the registers
		gap_pct = 20;
		stall_pct = 20;
		fill_random(300, 95);
		drain();

		set_regs(16'd1, 16'd2, 16'd3);
		push(1'b1, 1'b0, BST_UNKNOWN, 1'b1, 1'b1);
		push(1'b1, 1'b0, BST_UNDERV, 1'b1, 1'b1);
		push(1'b1, 1'b0, BST_LOW, 1'b1, 1'b1);
		push(1'b1, 1'b0, BST_GOOD, 1'b1, 1'b0);
		push(1'b1, 1'b0, BST_GOOD, 1'b1, 1'b0);
		push(1'b1, 1'b1, BST_GOOD, 1'b1, 1'b0);
		push(1'b1, 1'b1, BST_UNKNOWN, 1'b1, 1'b0);
		push(1'b1, 1'b1, BST_UNKNOWN, 1'b1, 1'b0);
		push(1'b1, 1'b1, BST_LOW, 1'b0, 1'b1);
		push(1'b1, 1'b1, BST_LOW, 1'b1, 1'b1);
		push(1'b1, 1'b0, BST_GOOD, 1'b1, 1'b1);
		push(1'b1, 1'b0, BST_GOOD, 1'b1, 1'b1);
		push(1'b1, 1'b0, BST_GOOD, 1'b1, 1'b1);
		push(1'b1, 1'b0, BST_LOW, 1'b1, 1'b1);
		push(1'b1, 1'b0, BST_UNDERV, 1'b1, 1'b0);
		push(1'b1, 1'b1, BST_UNDERV, 1'b1, 1'b0);
		push(1'b1, 1'b0, BST_UNKNOWN, 1'b1, 1'b0);
		push(1'b1, 1'b0, BST_UNDERV, 1'b1, 1'b0);
		push(1'b1, 1'b0, BST_UNDERV, 1'b1, 1'b0);
		push(1'b1, 1'b0, BST_UNDERV, 1'b0, 1'b1);
		push(1'b1, 1'b1, BST_UNKNOWN, 1'b1, 1'b1);
		push(1'b1, 1'b0, BST_UNKNOWN, 1'b1, 1'b1);
		push(1'b0, 1'b1, BST_GOOD, 1'b1, 1'b1);
		push(1'b1, 1'b1, BST_GOOD, 1'b0, 1'b0);
		push(1'b1, 1'b0, BST_GOOD, 1'b0, 1'b0);
		drain();

		set_regs(16'd2, 16'd4, 16'd6);
		fill_random(400, 70);
		drain();

		// no idling on either side
		gap_pct = 0;
		stall_pct = 0;
		set_regs(16'd20, 16'd1, 16'd2);
		fill_random(200, 95);
		drain();

		// divider lowered under a running prescaler
		gap_pct = 30;
		stall_pct = 10;
		set_regs(16'd3, 16'd0, 16'd0);
		fill_random(300, 50);
		drain();

		// upper data bits masked: divider of zero
		gap_pct = 10;
		stall_pct = 40;
		write_reg(REG_UNUSED, 16'hFFFF);
		set_regs(16'hFC00, 16'd3, 16'd10);
		fill_random(300, 40);
		drain();

		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
		fill_random(100, 90);
		drain();

		gap_pct = 5;
		stall_pct = 60;
		set_regs(16'd1, 16'd1, 16'd5);
		fill_random(400, 80);
		drain();

		repeat (8) @(negedge clk);
		if (mismatch_cnt == 0 && want_drive_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
